// ----- design/lfra_pkg.sv -----
// Shared types and constants for the lowest-free room allocator.
// No dependencies; every other design file imports this package.
package lfra_pkg;

  localparam int ROOMS_DEF   = 16;
  localparam int TIME_W      = 32;
  localparam int FIN_W       = 48;
  localparam int CNT_W       = 16;
  localparam int ROOM_W      = 4;
  localparam int NUM_W       = 5;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [NUM_W-1:0] NUM_RESET = NUM_W'(16);
  localparam logic [FIN_W-1:0] FIN_MAX   = '1;
  localparam logic [CNT_W-1:0] CNT_MAX   = '1;

  typedef struct packed {
    logic [TIME_W-1:0] start;
    logic [TIME_W-1:0] dur;
  } req_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SCAN,
    BK_DRAIN,
    BK_PICK,
    BK_COMMIT
  } bk_state_t;

  typedef struct packed {
    logic pop;
    logic scan;
    logic pick;
    logic commit;
  } bk_ctl_t;

endpackage

// ----- design/lfra_if.sv -----
// Channel interfaces for requests, results and the room-count register.
// Depends on lfra_pkg for field widths.
interface lfra_in_if import lfra_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] start_time;
  logic [TIME_W-1:0] end_time;
  modport source (output valid, start_time, end_time, input ready);
  modport sink   (input valid, start_time, end_time, output ready);
endinterface

interface lfra_out_if import lfra_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ROOM_W-1:0] room;
  logic              delayed;
  logic [FIN_W-1:0]  actual_start;
  logic [FIN_W-1:0]  actual_finish;
  logic [ROOM_W-1:0] top_room;
  logic [CNT_W-1:0]  top_count;
  modport source (output valid, room, delayed, actual_start, actual_finish, top_room,
                  top_count, input ready);
  modport sink   (input valid, room, delayed, actual_start, actual_finish, top_room,
                  top_count, output ready);
endinterface

interface lfra_cfg_if import lfra_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [NUM_W-1:0] num_rooms;
  modport source (output valid, num_rooms, input ready);
  modport sink   (input valid, num_rooms, output ready);
endinterface

// ----- design/lowest_free_room_allocator_unit.sv -----
// The back end handles one request at a time: it scans the finish-time memory one entry per
// cycle over the rooms in use, then passes through drain, pick and commit before the next.
// A two-beat queue and the output register let requests and results wait on either side
// without stalling the scan.
// Reset (synchronous, rst_n low): all finish times and counts read as zero, the top room
// is zero and the room count register returns to 16. No clearing pass is needed.
module lowest_free_room_allocator_unit import lfra_pkg::*; #(
  parameter int ROOMS = ROOMS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  lfra_in_if.sink     in_bus,
  lfra_out_if.source  out_bus,
  lfra_cfg_if.sink    cfg_bus
);

  localparam int RW = (ROOMS > 1) ? $clog2(ROOMS) : 1;

  logic [NUM_W-1:0] num_rooms_r;
  logic [RW-1:0]    last_idx;
  logic             q_valid;
  logic             q_pop;
  req_t             q_data;

  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_rooms_r <= NUM_RESET;
    end else if (cfg_bus.valid) begin
      num_rooms_r <= cfg_bus.num_rooms;
    end
  end

  always_comb begin
    if (num_rooms_r == '0) begin
      last_idx = '0;
    end else if (int'(num_rooms_r) > ROOMS) begin
      last_idx = RW'(ROOMS - 1);
    end else begin
      last_idx = RW'(num_rooms_r - 1'b1);
    end
  end

  lfra_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .q_data  (q_data)
  );

  lfra_back #(
    .ROOMS (ROOMS),
    .RW    (RW)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .last_idx (last_idx),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_data   (q_data),
    .out_bus  (out_bus)
  );

endmodule

// ----- design/lfra_front.sv -----
// Front end: accepts request beats, computes the clamped duration and queues them.
// Depends on lfra_pkg and lfra_in_if.
module lfra_front import lfra_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  lfra_in_if.sink  in_bus,
  output logic     q_valid,
  input  logic     q_pop,
  output req_t     q_data
);

  localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  req_t           buf_r [QUEUE_DEPTH];
  logic [QPW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0] cnt_r, cnt_nxt;
  logic           push;
  req_t           req;

  assign in_bus.ready = (cnt_r != QCW'(QUEUE_DEPTH));
  assign push         = in_bus.valid && in_bus.ready;
  assign q_valid      = (cnt_r != '0);
  assign q_data       = buf_r[rd_ptr_r];

  always_comb begin
    req.start = in_bus.start_time;
    req.dur   = (in_bus.end_time > in_bus.start_time) ?
                (in_bus.end_time - in_bus.start_time) : '0;
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({push, q_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= req;
    end
  end

endmodule

// ----- design/lfra_back.sv -----
// Back end: scans room finish times, picks a room, updates counts and the leader.
// Depends on lfra_pkg and lfra_out_if; holds the finish-time and count memories.
module lfra_back import lfra_pkg::*; #(
  parameter int ROOMS = ROOMS_DEF,
  parameter int RW    = (ROOMS > 1) ? $clog2(ROOMS) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [RW-1:0] last_idx,
  input  logic          q_valid,
  output logic          q_pop,
  input  req_t          q_data,
  lfra_out_if.source    out_bus
);

  bk_state_t         state_r, state_nxt;
  bk_ctl_t           ctl;

  logic [FIN_W-1:0]  fin_mem  [ROOMS];
  logic [CNT_W-1:0]  book_mem [ROOMS];
  logic [ROOMS-1:0]  vld_r;

  logic [FIN_W-1:0]  fin_rd_r;
  logic              fin_rdv_r;
  logic [CNT_W-1:0]  book_rd_r;
  logic              book_rdv_r;

  logic [RW-1:0]     scan_idx_r, chk_idx_r, last_r;
  logic              pend_r, found_r;
  logic [RW-1:0]     free_idx_r, min_idx_r, pick_r, pick_sel;
  logic [FIN_W-1:0]  min_r, act_start_r;
  logic [TIME_W-1:0] start_r, dur_r;
  logic              delayed_r;

  logic [RW-1:0]     best_r;
  logic [CNT_W-1:0]  best_cnt_r;
  logic [RW-1:0]     best_nxt;
  logic [CNT_W-1:0]  best_cnt_nxt;

  logic              out_valid_r, out_free;
  logic [FIN_W-1:0]  fin_val, fin_new;
  logic [FIN_W:0]    fin_sum;
  logic [CNT_W-1:0]  cnt_old, cnt_new;
  logic              free_hit;

  logic [ROOM_W-1:0] o_room_r, o_top_room_r;
  logic              o_delayed_r;
  logic [FIN_W-1:0]  o_start_r, o_finish_r;
  logic [CNT_W-1:0]  o_top_count_r;

  assign out_free = !out_valid_r || out_bus.ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE:   if (q_valid) state_nxt = BK_SCAN;
      BK_SCAN:   if (scan_idx_r == last_r) state_nxt = BK_DRAIN;
      BK_DRAIN:  state_nxt = BK_PICK;
      BK_PICK:   state_nxt = BK_COMMIT;
      BK_COMMIT: if (out_free) state_nxt = BK_IDLE;
      default:   state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    ctl        = '0;
    ctl.pop    = (state_r == BK_IDLE) && q_valid;
    ctl.scan   = (state_r == BK_SCAN);
    ctl.pick   = (state_r == BK_PICK);
    ctl.commit = (state_r == BK_COMMIT) && out_free;
  end

  assign q_pop = ctl.pop;

  assign fin_val  = fin_rdv_r ? fin_rd_r : '0;
  assign free_hit = (fin_val <= FIN_W'(start_r));
  assign pick_sel = found_r ? free_idx_r : min_idx_r;
  assign fin_sum  = {1'b0, act_start_r} + (FIN_W + 1)'(dur_r);
  assign fin_new  = fin_sum[FIN_W] ? FIN_MAX : fin_sum[FIN_W-1:0];
  assign cnt_old  = book_rdv_r ? book_rd_r : '0;
  assign cnt_new  = (cnt_old == CNT_MAX) ? cnt_old : cnt_old + 1'b1;

  always_comb begin
    best_nxt     = best_r;
    best_cnt_nxt = best_cnt_r;
    if (pick_r == best_r) begin
      best_cnt_nxt = cnt_new;
    end else if ((cnt_new > best_cnt_r) || ((cnt_new == best_cnt_r) && (pick_r < best_r))) begin
      best_nxt     = pick_r;
      best_cnt_nxt = cnt_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      pend_r      <= 1'b0;
      found_r     <= 1'b0;
      vld_r       <= '0;
      best_r      <= '0;
      best_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= ctl.scan;
      if (ctl.pop) begin
        found_r <= 1'b0;
      end else if (pend_r && !found_r && free_hit) begin
        found_r <= 1'b1;
      end
      if (ctl.commit) begin
        vld_r[pick_r] <= 1'b1;
        best_r        <= best_nxt;
        best_cnt_r    <= best_cnt_nxt;
        out_valid_r   <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    chk_idx_r <= scan_idx_r;
    if (ctl.pop) begin
      start_r    <= q_data.start;
      dur_r      <= q_data.dur;
      last_r     <= last_idx;
      scan_idx_r <= '0;
    end else if (ctl.scan && (scan_idx_r != last_r)) begin
      scan_idx_r <= scan_idx_r + 1'b1;
    end
    if (pend_r) begin
      if (!found_r && free_hit) begin
        free_idx_r <= chk_idx_r;
      end
      if ((chk_idx_r == '0) || (fin_val < min_r)) begin
        min_r     <= fin_val;
        min_idx_r <= chk_idx_r;
      end
    end
    if (ctl.pick) begin
      pick_r      <= pick_sel;
      delayed_r   <= !found_r;
      act_start_r <= found_r ? FIN_W'(start_r) : min_r;
    end
    if (ctl.commit) begin
      o_room_r      <= ROOM_W'(pick_r);
      o_delayed_r   <= delayed_r;
      o_start_r     <= act_start_r;
      o_finish_r    <= fin_new;
      o_top_room_r  <= ROOM_W'(best_nxt);
      o_top_count_r <= best_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      fin_mem[pick_r] <= fin_new;
    end
    fin_rd_r  <= fin_mem[scan_idx_r];
    fin_rdv_r <= vld_r[scan_idx_r];
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      book_mem[pick_r] <= cnt_new;
    end
    book_rd_r  <= book_mem[pick_sel];
    book_rdv_r <= vld_r[pick_sel];
  end

  assign out_bus.valid         = out_valid_r;
  assign out_bus.room          = o_room_r;
  assign out_bus.delayed       = o_delayed_r;
  assign out_bus.actual_start  = o_start_r;
  assign out_bus.actual_finish = o_finish_r;
  assign out_bus.top_room      = o_top_room_r;
  assign out_bus.top_count     = o_top_count_r;

endmodule
